/* hdl/pmtf_pkg.sv */
package pmtf_pkg;

  // Geometry of the address space and the page table.
  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned PAGE_SHIFT   = 8;
  localparam int unsigned VIRT_PAGES   = 256;
  localparam int unsigned PHYS_PAGES   = 64;
  localparam int unsigned PINNED_PAGES = 2;
  localparam int unsigned VP_W         = $clog2(VIRT_PAGES);
  localparam int unsigned FR_W         = $clog2(PHYS_PAGES);
  localparam int unsigned PAGE_W       = 8;
  localparam int unsigned FRAME_W      = 6;
  localparam int unsigned OLDEST_INIT  = 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGING_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_OFFS  = 2'd2;

  // Result kinds the controller asks the datapath to produce.
  localparam int unsigned EMIT_W = 3;
  localparam logic [EMIT_W-1:0] EMIT_NONE   = 3'd0;
  localparam logic [EMIT_W-1:0] EMIT_DIRECT = 3'd1;
  localparam logic [EMIT_W-1:0] EMIT_HIT    = 3'd2;
  localparam logic [EMIT_W-1:0] EMIT_NOFIND = 3'd3;
  localparam logic [EMIT_W-1:0] EMIT_EVICT  = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  phys_addr;
    logic               hit;
    logic               write_back;
    logic [PAGE_W-1:0]  victim_page;
    logic [PAGE_W-1:0]  load_page;
    logic [FRAME_W-1:0] frame;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              scan_start;
    logic              rd_load;
    logic              scan_adv;
    logic [EMIT_W-1:0] emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic paging_en;
    logic res_hit;
    logic found;
    logic last;
    logic out_free;
  } sts_t;

endpackage

/* hdl/pmtf_ctrl.sv */
module pmtf_ctrl
  import pmtf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EVICT = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.emit = EMIT_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.rd_load = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!sts_i.paging_en) begin
          if (sts_i.out_free) begin
            cmd_o.emit = EMIT_DIRECT;
            state_d    = ST_IDLE;
          end
        end else if (sts_i.res_hit) begin
          if (sts_i.out_free) begin
            cmd_o.emit = EMIT_HIT;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_load = 1'b1;
        if (sts_i.found) begin
          state_d = ST_EVICT;
        end else if (sts_i.last) begin
          // A full turn found nothing to evict.
          if (sts_i.out_free) begin
            cmd_o.emit = EMIT_NOFIND;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.scan_adv = 1'b1;
        end
      end
      ST_EVICT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_EVICT;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/pmtf_dp.sv */
module pmtf_dp
  import pmtf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  req_t                  in_req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output rsp_t                  out_rsp_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  // Configuration registers.
  logic              paging_en_q;
  logic [ADDR_W-1:0] bank_base_q;
  logic [ADDR_W-1:0] mem_offs_q;

  // Page table state.
  logic [VIRT_PAGES-1:0] resident_q;
  logic [VIRT_PAGES-1:0] written_q;
  logic [PHYS_PAGES-1:0] dirty_q;
  logic [FR_W-1:0]       frame_mem [VIRT_PAGES];
  logic [VP_W-1:0]       oldest_q;

  // Request being worked on.
  logic [ADDR_W-1:0] phy_q;
  logic              wr_q;
  logic [VP_W-1:0]   vp_q;
  logic              res_hit_q;

  // Frame table read port and victim scan.
  logic [FR_W-1:0] mem_rd_q;
  logic            wr_rd_q;
  logic [VP_W-1:0] rd_addr_q;
  logic [VP_W-1:0] scan_ptr_q;
  logic [VP_W-1:0] scan_cnt_q;

  // Output register.
  logic out_valid_q;
  rsp_t out_q;

  logic [ADDR_W-1:0] addr_in;
  logic [VP_W-1:0]   vp_in;
  logic [VP_W-1:0]   rd_addr;
  logic [FR_W-1:0]   frame_rd;
  logic [ADDR_W-1:0] phys_paged;
  logic              out_free;
  logic              emit;
  rsp_t              rsp_d;

  // Address translation into machine space and the virtual page index.
  assign addr_in = mem_offs_q + in_req_i.req_addr - bank_base_q;
  assign vp_in   = addr_in[PAGE_SHIFT +: VP_W];

  // The table is read at the requested page on accept, at the scan pointer otherwise.
  assign rd_addr  = cmd_i.accept ? vp_in : scan_ptr_q;
  assign frame_rd = wr_rd_q ? mem_rd_q : rd_addr_q[FR_W-1:0];

  assign phys_paged = (ADDR_W'(frame_rd) << PAGE_SHIFT)
                    | (phy_q & ADDR_W'((1 << PAGE_SHIFT) - 1));

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (cmd_i.emit != EMIT_NONE);

  assign sts_o.paging_en = paging_en_q;
  assign sts_o.res_hit   = res_hit_q;
  assign sts_o.found     = resident_q[scan_ptr_q]
                        && (scan_ptr_q >= VP_W'(PINNED_PAGES));
  assign sts_o.last      = (scan_cnt_q == VP_W'(VIRT_PAGES - 1));
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Result formatting for each kind.
  always_comb begin
    rsp_d = '0;
    case (cmd_i.emit)
      EMIT_DIRECT: begin
        rsp_d.phys_addr = phy_q;
        rsp_d.hit       = 1'b1;
      end
      EMIT_HIT: begin
        rsp_d.phys_addr = phys_paged;
        rsp_d.hit       = 1'b1;
        rsp_d.frame     = FRAME_W'(frame_rd);
      end
      EMIT_NOFIND: begin
        rsp_d.phys_addr = phy_q;
      end
      EMIT_EVICT: begin
        rsp_d.phys_addr   = phys_paged;
        rsp_d.write_back  = dirty_q[frame_rd];
        rsp_d.victim_page = PAGE_W'(scan_ptr_q);
        rsp_d.load_page   = PAGE_W'(vp_q);
        rsp_d.frame       = FRAME_W'(frame_rd);
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_en_q <= 1'b0;
      bank_base_q <= '0;
      mem_offs_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAGING_EN: paging_en_q <= cfg_data_i[0];
        CFG_BANK_BASE: bank_base_q <= cfg_data_i[ADDR_W-1:0];
        CFG_MEM_OFFS:  mem_offs_q  <= cfg_data_i[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      phy_q     <= addr_in;
      wr_q      <= in_req_i.req_type;
      vp_q      <= vp_in;
      res_hit_q <= resident_q[vp_in];
    end
  end

  // Frame table memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit == EMIT_EVICT) begin
      frame_mem[vp_q] <= frame_rd;
    end
    if (cmd_i.rd_load) begin
      mem_rd_q  <= frame_mem[rd_addr];
      wr_rd_q   <= written_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Victim scan pointer and counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      scan_ptr_q <= oldest_q;
      scan_cnt_q <= '0;
    end else if (cmd_i.scan_adv) begin
      scan_ptr_q <= scan_ptr_q + 1'b1;
      scan_cnt_q <= scan_cnt_q + 1'b1;
    end
  end

  // Residency, written marks, dirty bits and the FIFO pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VIRT_PAGES; i++) begin
        resident_q[i] <= (i < PHYS_PAGES);
      end
      written_q <= '0;
      dirty_q   <= '0;
      oldest_q  <= VP_W'(OLDEST_INIT);
    end else begin
      if (cmd_i.emit == EMIT_HIT && wr_q) begin
        dirty_q[frame_rd] <= 1'b1;
      end
      if (cmd_i.emit == EMIT_EVICT) begin
        resident_q[scan_ptr_q] <= 1'b0;
        resident_q[vp_q]       <= 1'b1;
        written_q[vp_q]        <= 1'b1;
        dirty_q[frame_rd]      <= wr_q;
        oldest_q               <= scan_ptr_q + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= rsp_d;
    end
  end

endmodule

/* hdl/paged_memory_translation_fifo.sv */
// Channel   Handshake                   Payload
// request   in_valid_i / in_ready_o     in_req_i   (req_t)
// result    out_valid_o / out_ready_i   out_rsp_o  (rsp_t)
// config    cfg_we_i                    cfg_idx_i, cfg_data_i
//
// A request with paging off or a resident page is accepted, then looked up.
// A miss adds a victim scan, one page per cycle from the FIFO pointer, then a read of
// the victim's frame if the scan finds a victim.
// A new request is accepted while a finished result still waits in the output register.
// Reset restores the page table at once through per-page residency and written bits.
module paged_memory_translation_fifo
  import pmtf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  req_t                  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rsp_t                  out_rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of lookup, victim scan and eviction.
  pmtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Page table, frame memory and result register.
  pmtf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
